[rtl/bps_pkg.sv]
// Shared types and constants for the buzzer pattern sequencer.
package bps_pkg;

  localparam int unsigned OPC_W   = 1;
  localparam int unsigned TONE_W  = 2;
  localparam int unsigned PAT_W   = 2;
  localparam int unsigned TICK_W  = 4;
  localparam int unsigned BURST_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [OPC_W-1:0] OPC_TICK = 1'b0;
  localparam logic [OPC_W-1:0] OPC_SET  = 1'b1;

  localparam logic [TONE_W-1:0] TONE_MUTE  = 2'd0;
  localparam logic [TONE_W-1:0] TONE_BEEP  = 2'd1;
  localparam logic [TONE_W-1:0] TONE_ALARM = 2'd2;
  localparam logic [TONE_W-1:0] TONE_END   = 2'd3;

  localparam logic [PAT_W-1:0] PAT_IDLE  = 2'd0;
  localparam logic [PAT_W-1:0] PAT_BEEP  = 2'd1;
  localparam logic [PAT_W-1:0] PAT_ALARM = 2'd2;
  localparam logic [PAT_W-1:0] PAT_END   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_END_ON      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_OFF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_REPEATS = 2'd2;

  localparam logic [TICK_W-1:0]  END_ON_RST      = 4'd5;
  localparam logic [TICK_W-1:0]  END_OFF_RST     = 4'd10;
  localparam logic [BURST_W-1:0] END_REPEATS_RST = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [TONE_W-1:0] tone;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0]  end_on_ticks;
    logic [TICK_W-1:0]  end_off_ticks;
    logic [BURST_W-1:0] end_repeats;
  } cfg_t;

  typedef struct packed {
    logic              buzzer_on;
    logic [PAT_W-1:0]  active_pattern;
  } result_t;

endpackage

[rtl/bps_in_if.sv]
// Input channel: tick or tone command beats.
interface bps_in_if;
  logic                       valid;
  logic                       ready;
  logic [bps_pkg::OPC_W-1:0]  opcode;
  logic [bps_pkg::TONE_W-1:0] tone;

  modport source (output valid, output opcode, output tone, input ready);
  modport sink   (input valid, input opcode, input tone, output ready);
endinterface

[rtl/bps_out_if.sv]
// Result channel: buzzer level and running pattern beats.
interface bps_out_if;
  logic                      valid;
  logic                      ready;
  logic                      buzzer_on;
  logic [bps_pkg::PAT_W-1:0] active_pattern;

  modport source (output valid, output buzzer_on, output active_pattern, input ready);
  modport sink   (input valid, input buzzer_on, input active_pattern, output ready);
endinterface

[rtl/bps_cfg_if.sv]
// Configuration write channel.
interface bps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::CFG_IDX_W-1:0]  index;
  logic [bps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/buzzer_pattern_sequencer_top.sv]
// Top level of the buzzer pattern sequencer.
// Usage:
//   in_if carries one beat per tick (opcode 0) or tone command (opcode 1,
//   tone 0 mute, 1 beep, 2 alarm, 3 end). Each accepted beat gives exactly
//   one beat on out_if with the buzzer level and the running pattern.
//   cfg_if writes end_on_ticks (index 0), end_off_ticks (index 1) and
//   end_repeats (index 2); it is always ready, and index 3 is dropped.
//   out_if.valid is high in the cycle after an input accept. The pattern
//   state machine steps once per accepted beat, so a new beat can enter
//   every cycle: throughput is one beat per cycle while out_if drains.
//   in_if.ready is high whenever the result register is empty or is being
//   taken in the same cycle. When the receiver stalls, the result holds and
//   the input waits behind it.
//   Reset (rst_n low, synchronous) returns the pattern to idle with the
//   buzzer off, empties the result register and restores the register
//   defaults 5, 10 and 3.
module buzzer_pattern_sequencer_top (
  input  logic      clk,
  input  logic      rst_n,
  bps_in_if.sink    in_if,
  bps_out_if.source out_if,
  bps_cfg_if.sink   cfg_if
);

  bps_pkg::cfg_t    cfg_r;
  bps_pkg::cmd_t    cmd;
  bps_pkg::result_t step_res;
  logic             in_accept;
  logic             out_valid_r, out_valid_nxt;
  bps_pkg::result_t out_res_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_on_ticks  <= bps_pkg::END_ON_RST;
      cfg_r.end_off_ticks <= bps_pkg::END_OFF_RST;
      cfg_r.end_repeats   <= bps_pkg::END_REPEATS_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        bps_pkg::CFG_END_ON:      cfg_r.end_on_ticks  <= cfg_if.data;
        bps_pkg::CFG_END_OFF:     cfg_r.end_off_ticks <= cfg_if.data;
        bps_pkg::CFG_END_REPEATS: cfg_r.end_repeats   <= cfg_if.data[bps_pkg::BURST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;
  assign cmd.opcode  = in_if.opcode;
  assign cmd.tone    = in_if.tone;

  bps_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .cmd     (cmd),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  assign out_valid_nxt = in_accept || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res_r <= step_res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.buzzer_on      = out_res_r.buzzer_on;
  assign out_if.active_pattern = out_res_r.active_pattern;

endmodule

[rtl/bps_engine.sv]
// Pattern state machine: one step per accepted beat.
module bps_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  bps_pkg::cmd_t    cmd,
  input  bps_pkg::cfg_t    cfg,
  output bps_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_BEEP      = 3'd1,
    PH_ALARM_ON  = 3'd2,
    PH_ALARM_OFF = 3'd3,
    PH_END_ON    = 3'd4,
    PH_END_OFF   = 3'd5
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [bps_pkg::TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic [bps_pkg::BURST_W-1:0]  burst_r, burst_nxt, burst_inc;
  logic                         drive_r, drive_nxt;

  assign tick_inc  = tick_r + 1'b1;
  assign burst_inc = burst_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    burst_nxt = burst_r;
    drive_nxt = drive_r;
    if (cmd.opcode == bps_pkg::OPC_SET) begin
      case (cmd.tone)
        bps_pkg::TONE_MUTE: begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          drive_nxt = 1'b0;
        end
        bps_pkg::TONE_BEEP: begin
          phase_nxt = PH_BEEP;
          tick_nxt  = '0;
          drive_nxt = 1'b1;
        end
        bps_pkg::TONE_ALARM: begin
          // A running alarm keeps its rhythm.
          if (phase_r != PH_ALARM_ON && phase_r != PH_ALARM_OFF) begin
            phase_nxt = PH_ALARM_ON;
            tick_nxt  = '0;
            drive_nxt = 1'b1;
          end
        end
        default: begin
          if (phase_r != PH_END_ON && phase_r != PH_END_OFF) begin
            phase_nxt = PH_END_ON;
            tick_nxt  = '0;
            burst_nxt = '0;
            drive_nxt = 1'b1;
          end
        end
      endcase
    end else begin
      case (phase_r)
        PH_IDLE: begin
          tick_nxt  = '0;
          burst_nxt = '0;
          drive_nxt = 1'b0;
        end
        PH_BEEP: begin
          // The buzzer keeps sounding for one more tick after going idle.
          tick_nxt = tick_inc;
          if (tick_inc == bps_pkg::TICK_W'(1)) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_ALARM_ON: begin
          tick_nxt = tick_inc;
          if (tick_inc == bps_pkg::TICK_W'(1)) begin
            tick_nxt  = '0;
            phase_nxt = PH_ALARM_OFF;
            drive_nxt = 1'b0;
          end
        end
        PH_ALARM_OFF: begin
          tick_nxt = tick_inc;
          if (tick_inc == bps_pkg::TICK_W'(1)) begin
            tick_nxt  = '0;
            phase_nxt = PH_ALARM_ON;
            drive_nxt = 1'b1;
          end
        end
        PH_END_ON: begin
          tick_nxt = tick_inc;
          if (tick_inc == cfg.end_on_ticks) begin
            burst_nxt = burst_inc;
            tick_nxt  = '0;
            drive_nxt = 1'b0;
            phase_nxt = (burst_inc >= cfg.end_repeats) ? PH_IDLE : PH_END_OFF;
          end
        end
        PH_END_OFF: begin
          tick_nxt = tick_inc;
          if (tick_inc == cfg.end_off_ticks) begin
            tick_nxt  = '0;
            phase_nxt = PH_END_ON;
            drive_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.buzzer_on = drive_nxt;
    case (phase_nxt)
      PH_BEEP:                  result.active_pattern = bps_pkg::PAT_BEEP;
      PH_ALARM_ON, PH_ALARM_OFF: result.active_pattern = bps_pkg::PAT_ALARM;
      PH_END_ON, PH_END_OFF:    result.active_pattern = bps_pkg::PAT_END;
      default:                  result.active_pattern = bps_pkg::PAT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      burst_r <= '0;
      drive_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      burst_r <= burst_nxt;
      drive_r <= drive_nxt;
    end
  end

endmodule

[rtl/bps_checker.sv]
// Port-level checks for the buzzer pattern sequencer, bound to the top level.
module bps_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [bps_pkg::OPC_W-1:0] in_opcode,
  input logic [bps_pkg::TONE_W-1:0] in_tone,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_buzzer_on,
  input logic [bps_pkg::PAT_W-1:0] out_active_pattern
);

  // Every accepted beat shows a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_buzzer_on) && $stable(out_active_pattern)))
    else $error("stalled result beat changed");

  // Mute silences the buzzer and idles the pattern at once.
  a_mute: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == bps_pkg::OPC_SET &&
     in_tone == bps_pkg::TONE_MUTE) |=>
      (!out_buzzer_on && out_active_pattern == bps_pkg::PAT_IDLE))
    else $error("mute did not silence the buzzer");

  // Beep always restarts with the buzzer sounding.
  a_beep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == bps_pkg::OPC_SET &&
     in_tone == bps_pkg::TONE_BEEP) |=>
      (out_buzzer_on && out_active_pattern == bps_pkg::PAT_BEEP))
    else $error("beep did not start the buzzer");

endmodule

bind buzzer_pattern_sequencer_top bps_port_checker u_bps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_opcode          (in_if.opcode),
  .in_tone            (in_if.tone),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_buzzer_on      (out_if.buzzer_on),
  .out_active_pattern (out_if.active_pattern)
);
